@@ src/stpars_pkg.sv @@
// Shared types and constants for the segment tree range sum block.
package stpars_pkg;

  localparam int VAL_W = 64;
  localparam int POS_W = 10;
  localparam int LEN_CFG_W = 11;
  localparam int LEN_RESET = 1024;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOB = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_run;
    logic upd_step;
    logic qry_step;
    logic acc_add;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_oob;
    logic clr_last;
    logic upd_last;
    logic qry_done;
  } sts_t;

endpackage

@@ src/segment_tree_point_assign_range_sum.sv @@
// Top level of the segment tree range sum block with point assignment.
// An update writes the leaf and then refreshes one parent per tree level; a query
// walks up one level per cycle and ends with a two stage accumulate; an
// out-of-range update skips the tree walk and goes straight to the result.
// Throughput: one item at a time, set by the single tree walk over the node memory.
// Reset and every length write start a clearing pass over all 2*MAX_LEAVES nodes.
module segment_tree_point_assign_range_sum import stpars_pkg::*; #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LEN_CFG_W-1:0]    cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        left_i,
  input  logic [POS_W-1:0]        right_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] range_sum_o,
  output logic                    status_o
);

  // The tree is kept in the flat bottom-up layout: leaf p sits at node
  // MAX_LEAVES + p and node i holds the sum of nodes 2i and 2i+1. Because
  // sums wrap modulo 2^64 and addition is associative, any tree shape
  // gives the same range sums, so this layout needs only 2*MAX_LEAVES nodes.

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] range_sum;

  // The controller sequences the clearing sweep after reset or a length
  // write, the leaf-to-root refresh of an update, and the two-pointer
  // query walk. It accepts a new transfer only while idle, and a finished
  // result waits in the output register so the next item may enter.
  stpars_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // The datapath holds the node memory with one write and two read ports.
  // An update writes the leaf, then climbs one level per cycle, reading the
  // sibling and writing the parent. A query moves its left and right
  // pointers up one level per cycle and reads at most one node on each
  // side; those reads are summed and then added into the accumulator.
  stpars_dp #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .left_i      (left_i),
    .right_i     (right_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .range_sum_o (range_sum),
    .status_o    (status_o)
  );

  assign range_sum_o = range_sum;

endmodule

@@ src/stpars_ctrl.sv @@
// Controller state machine that sequences clearing, updates, queries and results.
module stpars_ctrl import stpars_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic in_valid_i,
  input  logic op_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o,
  output logic out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_i == OP_QUERY) begin
            state_d = ST_QRY;
          end else if (sts_i.in_oob) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.upd_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_QRY: begin
        cmd_o.qry_step = 1'b1;
        cmd_o.acc_add  = 1'b1;
        if (sts_i.qry_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // A length write reshapes the tree, so the store is swept again.
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end

    priority if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/stpars_dp.sv @@
// Datapath: node sum memory, tree walk pointers, accumulator and result register.
module stpars_dp import stpars_pkg::*; #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LEN_CFG_W-1:0] cfg_wdata_i,
  input  logic                 op_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [VAL_W-1:0]     value_i,
  input  logic [POS_W-1:0]     left_i,
  input  logic [POS_W-1:0]     right_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [VAL_W-1:0]     range_sum_o,
  output logic                 status_o
);

  localparam int Depth    = 2 * MAX_LEAVES;
  localparam int AW       = $clog2(Depth);
  localparam int PW       = AW + 1;
  localparam int LW       = $clog2(MAX_LEAVES + 1);
  localparam int ResetLen = (MAX_LEAVES < LEN_RESET) ? MAX_LEAVES : LEN_RESET;

  logic [VAL_W-1:0] node_sums_q [Depth];

  logic [LW-1:0]    len_q, len_d;
  logic [AW-1:0]    clr_cnt_q;
  logic [AW-1:0]    node_q;
  logic [VAL_W-1:0] acc_q;
  logic [PW-1:0]    l_q, r_q;
  logic             vl_q, vr_q;
  logic [VAL_W-1:0] rd_a_q, rd_b_q;
  logic [VAL_W-1:0] pair_q, pair_d;
  logic             op_q, oob_q;
  logic [VAL_W-1:0] res_sum_q;
  logic             res_status_q;

  logic [31:0]      cfg_ext, len_ext, pos_ext, ql_ext, qr_ext, qr_clip;
  logic             qry_empty, in_oob, lt, do_leaf;
  logic [AW-1:0]    leaf, parent, raddr_a, raddr_b, waddr;
  logic [PW-1:0]    l_init, r_init, r_m1;
  logic [VAL_W-1:0] upd_sum, wdata;
  logic             we;

  always_comb begin
    cfg_ext = 32'(cfg_wdata_i);
    priority if (cfg_ext == 32'd0) begin
      len_d = LW'(1);
    end else if (cfg_ext > 32'(MAX_LEAVES)) begin
      len_d = LW'(MAX_LEAVES);
    end else begin
      len_d = LW'(cfg_ext);
    end
  end

  always_comb begin
    len_ext   = 32'(len_q);
    pos_ext   = 32'(position_i);
    ql_ext    = 32'(left_i);
    qr_ext    = 32'(right_i);
    in_oob    = (pos_ext >= len_ext);
    qr_clip   = (qr_ext >= len_ext) ? (len_ext - 32'd1) : qr_ext;
    qry_empty = (ql_ext > qr_clip);
    leaf      = AW'(MAX_LEAVES) + AW'(position_i);
    l_init    = qry_empty ? '0 : PW'(MAX_LEAVES) + PW'(left_i);
    r_init    = qry_empty ? '0 : PW'(MAX_LEAVES) + PW'(qr_clip) + PW'(1);
    parent    = node_q >> 1;
    upd_sum   = acc_q + rd_a_q;
    lt        = (l_q < r_q);
    r_m1      = r_q - PW'(1);
    do_leaf   = cmd_i.accept && (op_i == OP_ASSIGN) && !in_oob;
    pair_d    = (vl_q ? rd_a_q : '0) + (vr_q ? rd_b_q : '0);
  end

  // One write port: clearing sweep, leaf write, or a parent refresh.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_q;
    wdata = '0;
    priority if (cmd_i.clr_run) begin
      we = 1'b1;
    end else if (do_leaf) begin
      we    = 1'b1;
      waddr = leaf;
      wdata = value_i;
    end else if (cmd_i.upd_step) begin
      we    = 1'b1;
      waddr = parent;
      wdata = upd_sum;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd_i.accept) begin
      raddr_a = {leaf[AW-1:1], ~leaf[0]};
    end else if (cmd_i.upd_step) begin
      raddr_a = {parent[AW-1:1], ~parent[0]};
    end else begin
      raddr_a = l_q[AW-1:0];
    end
    raddr_b = r_m1[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      node_sums_q[waddr] <= wdata;
    end
    rd_a_q <= node_sums_q[raddr_a];
    rd_b_q <= node_sums_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LW'(ResetLen);
      clr_cnt_q <= '0;
      vl_q      <= 1'b0;
      vr_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q     <= len_d;
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_run) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      vl_q <= cmd_i.qry_step && lt && l_q[0];
      vr_q <= cmd_i.qry_step && lt && r_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    if (cmd_i.accept) begin
      op_q  <= op_i;
      oob_q <= (op_i == OP_ASSIGN) && in_oob;
      node_q <= leaf;
      l_q    <= l_init;
      r_q    <= r_init;
      acc_q  <= (op_i == OP_QUERY) ? '0 : value_i;
    end else if (cmd_i.upd_step) begin
      node_q <= parent;
      acc_q  <= upd_sum;
    end else begin
      if (cmd_i.qry_step && lt) begin
        l_q <= (l_q + PW'(l_q[0])) >> 1;
        r_q <= (r_q - PW'(r_q[0])) >> 1;
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_q + pair_q;
      end
    end
    if (cmd_i.load_result) begin
      res_sum_q    <= (op_q == OP_QUERY) ? acc_q : '0;
      res_status_q <= oob_q ? STATUS_OOB : STATUS_OK;
    end
  end

  assign sts_o.in_oob   = in_oob;
  assign sts_o.clr_last = (clr_cnt_q == AW'(Depth - 1));
  assign sts_o.upd_last = (parent == AW'(1));
  assign sts_o.qry_done = !lt;

  assign range_sum_o = res_sum_q;
  assign status_o    = res_status_q;

endmodule
